[design/lgnc_pkg.sv]
// lgnc_pkg: shared types and constants for the line grid node classifier
// no dependencies; imported by line_grid_node_classifier
`default_nettype none

package lgnc_pkg;

    localparam int SENSOR_BITS_DEF = 10;
    localparam int LEVEL_BITS      = 10;
    localparam int STEP_BITS       = 16;
    localparam int COUNT_BITS      = 16;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 16;
    localparam int DIR_BITS        = 4;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // direction mask bit positions
    localparam int DIR_UP_BIT    = 0;
    localparam int DIR_RIGHT_BIT = 1;
    localparam int DIR_DOWN_BIT  = 2;
    localparam int DIR_LEFT_BIT  = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WHITE_LEVEL        = 3'd0,
        CFG_BLACK_LEVEL        = 3'd1,
        CFG_CENTER_DISTANCE    = 3'd2,
        CFG_CROSSING_LEVEL     = 3'd3,
        CFG_BACK_WINDOW_END    = 3'd4,
        CFG_FRONT_WINDOW_START = 3'd5
    } t_cfg_idx;

    localparam logic [LEVEL_BITS-1:0] WHITE_LEVEL_RST        = 10'd600;
    localparam logic [LEVEL_BITS-1:0] BLACK_LEVEL_RST        = 10'd300;
    localparam logic [STEP_BITS-1:0]  CENTER_DISTANCE_RST    = 16'd100;
    localparam logic [LEVEL_BITS-1:0] CROSSING_LEVEL_RST     = 10'd400;
    localparam logic [STEP_BITS-1:0]  BACK_WINDOW_END_RST    = 16'd40;
    localparam logic [STEP_BITS-1:0]  FRONT_WINDOW_START_RST = 16'd60;

endpackage

`default_nettype wire

[design/line_grid_node_classifier.sv]
// line_grid_node_classifier: input register, one stage of classify logic, result register
// each item passes the input register; its result is held in the result register
// throughput: one item per cycle unless stalled; accumulators update at most once per item
// reset: synchronous active-low; clears valids, detection state, accumulators, and
// restores the threshold registers to their defaults
// depends on lgnc_pkg
`default_nettype none

module line_grid_node_classifier #(
    parameter int SENSOR_BITS = lgnc_pkg::SENSOR_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [lgnc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [lgnc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    // input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_enabled,
    input  wire logic                              i_returning,
    input  wire logic                              i_abort,
    input  wire logic [SENSOR_BITS-1:0]            i_sense_left,
    input  wire logic [SENSOR_BITS-1:0]            i_sense_middle,
    input  wire logic [SENSOR_BITS-1:0]            i_sense_right,
    input  wire logic [lgnc_pkg::STEP_BITS-1:0]    i_wheel_steps_left,
    input  wire logic [lgnc_pkg::STEP_BITS-1:0]    i_wheel_steps_right,
    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_acted,
    output logic                                   o_started,
    output logic                                   o_finished,
    output logic                                   o_finished_returning,
    output logic [lgnc_pkg::DIR_BITS-1:0]          o_direction_mask
);
    import lgnc_pkg::*;

    localparam int SUM_W  = SENSOR_BITS + COUNT_BITS;
    localparam int PROD_W = LEVEL_BITS + COUNT_BITS;
    localparam int CMPS_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int CMPL_W = (SENSOR_BITS > LEVEL_BITS) ? SENSOR_BITS : LEVEL_BITS;

    // configuration
    logic [LEVEL_BITS-1:0] r_white_level, r_black_level, r_crossing_level;
    logic [STEP_BITS-1:0]  r_center_distance, r_back_window_end, r_front_window_start;

    // input register
    logic                   r_in_vld;
    logic                   r_enabled, r_returning, r_abort;
    logic [SENSOR_BITS-1:0] r_sl, r_sm, r_sr;
    logic [STEP_BITS-1:0]   r_wl, r_wr;

    // detection state
    logic                  r_detecting, n_detecting;
    logic [STEP_BITS-1:0]  r_start_l, r_start_r, n_start_l, n_start_r;
    logic [SUM_W-1:0]      r_sum_bl, r_sum_br, r_sum_fl, r_sum_fr;
    logic [SUM_W-1:0]      n_sum_bl, n_sum_br, n_sum_fl, n_sum_fr;
    logic [COUNT_BITS-1:0] r_cnt_back, r_cnt_front, n_cnt_back, n_cnt_front;

    // result register
    logic                r_out_vld;
    logic                r_acted, r_started, r_finished, r_fin_ret;
    logic [DIR_BITS-1:0] r_mask;
    logic                n_acted, n_started, n_finished, n_fin_ret;
    logic [DIR_BITS-1:0] n_mask;

    logic adv;

    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;

    // classify logic
    logic                  det_eff, white_seen, at_center, in_back, in_front, black_seen;
    logic [STEP_BITS-1:0]  dl, dr;
    logic [PROD_W-1:0]     prod_back, prod_front;
    logic                  cross_bl, cross_br, cross_fl, cross_fr;

    assign det_eff    = r_detecting && !r_abort;
    assign white_seen = CMPL_W'(r_sm) > CMPL_W'(r_white_level);
    assign black_seen = (CMPL_W'(r_sl) < CMPL_W'(r_black_level)) ||
                        (CMPL_W'(r_sm) < CMPL_W'(r_black_level)) ||
                        (CMPL_W'(r_sr) < CMPL_W'(r_black_level));
    assign dl         = r_wl - r_start_l;
    assign dr         = r_wr - r_start_r;
    assign at_center  = (dl >= r_center_distance) && (dr >= r_center_distance);
    assign in_back    = (dl < r_back_window_end) && (dr < r_back_window_end);
    assign in_front   = (dl > r_front_window_start) && (dr > r_front_window_start);

    assign prod_back  = PROD_W'(r_crossing_level) * PROD_W'(r_cnt_back);
    assign prod_front = PROD_W'(r_crossing_level) * PROD_W'(r_cnt_front);
    // zero count gives zero product, so an empty window never reports a crossing
    assign cross_bl   = CMPS_W'(r_sum_bl) < CMPS_W'(prod_back);
    assign cross_br   = CMPS_W'(r_sum_br) < CMPS_W'(prod_back);
    assign cross_fl   = CMPS_W'(r_sum_fl) < CMPS_W'(prod_front);
    assign cross_fr   = CMPS_W'(r_sum_fr) < CMPS_W'(prod_front);

    always_comb begin
        n_detecting = det_eff;
        n_start_l   = r_start_l;
        n_start_r   = r_start_r;
        n_sum_bl    = r_sum_bl;
        n_sum_br    = r_sum_br;
        n_sum_fl    = r_sum_fl;
        n_sum_fr    = r_sum_fr;
        n_cnt_back  = r_cnt_back;
        n_cnt_front = r_cnt_front;
        n_acted     = 1'b0;
        n_started   = 1'b0;
        n_finished  = 1'b0;
        n_fin_ret   = 1'b0;
        n_mask      = '0;
        if (r_enabled) begin
            if (!det_eff) begin
                if (white_seen) begin
                    n_sum_bl    = '0;
                    n_sum_br    = '0;
                    n_sum_fl    = '0;
                    n_sum_fr    = '0;
                    n_cnt_back  = '0;
                    n_cnt_front = '0;
                    n_start_l   = r_wl;
                    n_start_r   = r_wr;
                    n_detecting = 1'b1;
                    n_acted     = 1'b1;
                    n_started   = 1'b1;
                end
            end else if (at_center) begin
                n_mask[DIR_DOWN_BIT]  = 1'b1;
                n_mask[DIR_UP_BIT]    = black_seen;
                n_mask[DIR_LEFT_BIT]  = cross_bl || cross_fl;
                n_mask[DIR_RIGHT_BIT] = cross_br || cross_fr;
                n_finished  = 1'b1;
                n_fin_ret   = r_returning;
                n_detecting = 1'b0;
                n_acted     = 1'b1;
            end else if (white_seen) begin
                // saturated windows drop further samples
                if (in_back) begin
                    if (r_cnt_back != COUNT_MAX) begin
                        n_sum_bl   = r_sum_bl + SUM_W'(r_sl);
                        n_sum_br   = r_sum_br + SUM_W'(r_sr);
                        n_cnt_back = r_cnt_back + COUNT_BITS'(1);
                    end
                end else if (in_front) begin
                    if (r_cnt_front != COUNT_MAX) begin
                        n_sum_fl    = r_sum_fl + SUM_W'(r_sl);
                        n_sum_fr    = r_sum_fr + SUM_W'(r_sr);
                        n_cnt_front = r_cnt_front + COUNT_BITS'(1);
                    end
                end
                n_acted = 1'b1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white_level        <= WHITE_LEVEL_RST;
            r_black_level        <= BLACK_LEVEL_RST;
            r_center_distance    <= CENTER_DISTANCE_RST;
            r_crossing_level     <= CROSSING_LEVEL_RST;
            r_back_window_end    <= BACK_WINDOW_END_RST;
            r_front_window_start <= FRONT_WINDOW_START_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WHITE_LEVEL:        r_white_level        <= i_cfg_data[LEVEL_BITS-1:0];
                CFG_BLACK_LEVEL:        r_black_level        <= i_cfg_data[LEVEL_BITS-1:0];
                CFG_CENTER_DISTANCE:    r_center_distance    <= i_cfg_data[STEP_BITS-1:0];
                CFG_CROSSING_LEVEL:     r_crossing_level     <= i_cfg_data[LEVEL_BITS-1:0];
                CFG_BACK_WINDOW_END:    r_back_window_end    <= i_cfg_data[STEP_BITS-1:0];
                CFG_FRONT_WINDOW_START: r_front_window_start <= i_cfg_data[STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_enabled   <= i_enabled;
            r_returning <= i_returning;
            r_abort     <= i_abort;
            r_sl        <= i_sense_left;
            r_sm        <= i_sense_middle;
            r_sr        <= i_sense_right;
            r_wl        <= i_wheel_steps_left;
            r_wr        <= i_wheel_steps_right;
        end
    end

    // detection state, advances once per item leaving the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detecting <= 1'b0;
            r_start_l   <= '0;
            r_start_r   <= '0;
            r_sum_bl    <= '0;
            r_sum_br    <= '0;
            r_sum_fl    <= '0;
            r_sum_fr    <= '0;
            r_cnt_back  <= '0;
            r_cnt_front <= '0;
        end else if (adv) begin
            r_detecting <= n_detecting;
            r_start_l   <= n_start_l;
            r_start_r   <= n_start_r;
            r_sum_bl    <= n_sum_bl;
            r_sum_br    <= n_sum_br;
            r_sum_fl    <= n_sum_fl;
            r_sum_fr    <= n_sum_fr;
            r_cnt_back  <= n_cnt_back;
            r_cnt_front <= n_cnt_front;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (adv) begin
            r_acted   <= n_acted;
            r_started <= n_started;
            r_finished <= n_finished;
            r_fin_ret <= n_fin_ret;
            r_mask    <= n_mask;
        end
    end

    assign o_out_valid          = r_out_vld;
    assign o_acted              = r_acted;
    assign o_started            = r_started;
    assign o_finished           = r_finished;
    assign o_finished_returning = r_fin_ret;
    assign o_direction_mask     = r_mask;

endmodule

`default_nettype wire
